### sv/shs_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
// Holds the round constant table, the initial hash values and the
// command/status structs between controller and datapath. No dependencies.
package shs_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned BLK_BITS   = 512;

    localparam logic [31:0] K_ROUND [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic       MODE_ABSORB = 1'b0;
    localparam logic       MODE_FINISH = 1'b1;

    typedef enum logic [1:0] {
        SEL_DATA  = 2'd0,
        SEL_PAD80 = 2'd1,
        SEL_ZERO  = 2'd2,
        SEL_LEN   = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic      shift_en;
        t_byte_sel byte_sel;
        logic      count_bits;
        logic      load_vars;
        logic      round_en;
        logic [5:0] round_idx;
        logic      add_chain;
        logic      clear_msg;
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] byte_cnt;
    } t_dp_status;

endpackage

### sv/shs_datapath.sv
// Datapath of the SHA-256 stream hasher: block shift register that doubles
// as the message schedule window, round variables, chaining words, counters.
// Depends on shs_pkg.
module shs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shs_pkg::t_dp_cmd    i_cmd,
    input  logic [7:0]          i_data_byte,
    output shs_pkg::t_dp_status o_status,
    output logic [31:0]         o_digest_word
);
    import shs_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [BLK_BITS-1:0] r_blk, n_blk;
    logic [31:0]         r_v [NUM_WORDS];
    logic [31:0]         r_chain [NUM_WORDS];
    logic [5:0]          r_cnt;
    logic [63:0]         r_bits;

    logic [7:0]  shift_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] s0, s1, big_s0, big_s1, ch, maj, t1, t2;

    always_comb begin
        unique case (i_cmd.byte_sel)
            SEL_DATA:  shift_byte = i_data_byte;
            SEL_PAD80: shift_byte = PAD_BYTE;
            SEL_ZERO:  shift_byte = 8'h00;
            SEL_LEN:   shift_byte = 8'(r_bits >> {~r_cnt[2:0], 3'b000});
            default:   shift_byte = 8'h00;
        endcase
    end

    assign w0  = r_blk[BLK_BITS-1        -: 32];
    assign w1  = r_blk[BLK_BITS-1-32*1   -: 32];
    assign w9  = r_blk[BLK_BITS-1-32*9   -: 32];
    assign w14 = r_blk[BLK_BITS-1-32*14  -: 32];

    assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = s1 + w9 + s0 + w0;

    assign big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1     = r_v[7] + big_s1 + ch + K_ROUND[i_cmd.round_idx] + w0;
    assign t2     = big_s0 + maj;

    always_comb begin
        n_blk = r_blk;
        if (i_cmd.shift_en) begin
            n_blk = {r_blk[BLK_BITS-9:0], shift_byte};
        end else if (i_cmd.round_en) begin
            n_blk = {r_blk[BLK_BITS-33:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (i_cmd.load_vars) begin
            for (int i = 0; i < NUM_WORDS; i++) r_v[i] <= r_chain[i];
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_msg) begin
            for (int i = 0; i < NUM_WORDS; i++) r_chain[i] <= H_INIT[i];
            r_cnt  <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.add_chain) begin
                for (int i = 0; i < NUM_WORDS; i++) r_chain[i] <= r_chain[i] + r_v[i];
            end
            if (i_cmd.shift_en) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (i_cmd.count_bits) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    assign o_status.byte_cnt = r_cnt;
    assign o_digest_word     = r_chain[i_cmd.out_idx];

endmodule

### sv/shs_ctrl.sv
// Controller of the SHA-256 stream hasher: absorb, padding, round sequencing
// and digest output. Drives the datapath through shs_pkg command/status structs.
// Depends on shs_pkg.
module shs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_word_index,
    output logic                o_last_word,
    input  shs_pkg::t_dp_status i_status,
    output shs_pkg::t_dp_cmd    o_cmd
);
    import shs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_INIT  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_oidx, n_oidx;
    logic       r_fin, n_fin;
    logic       r_final, n_final;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_oidx  = r_oidx;
        n_fin   = r_fin;
        n_final = r_final;
        o_cmd            = '0;
        o_cmd.byte_sel   = SEL_ZERO;
        o_cmd.round_idx  = r_round;
        o_cmd.out_idx    = r_oidx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.shift_en = 1'b1;
                    if (i_mode == MODE_ABSORB) begin
                        o_cmd.byte_sel   = SEL_DATA;
                        o_cmd.count_bits = 1'b1;
                        n_fin = 1'b0;
                        if (i_status.byte_cnt == 6'd63) n_state = S_INIT;
                    end else begin
                        o_cmd.byte_sel = SEL_PAD80;
                        n_fin   = 1'b1;
                        n_final = (i_status.byte_cnt < 6'd56);
                        n_state = (i_status.byte_cnt == 6'd63) ? S_INIT : S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_en = 1'b1;
                o_cmd.byte_sel = (r_final && i_status.byte_cnt >= 6'd56) ? SEL_LEN : SEL_ZERO;
                if (i_status.byte_cnt == 6'd63) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.load_vars = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_final) begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end else begin
                    n_final = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_oidx == 3'd7) begin
                        o_cmd.clear_msg = 1'b1;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_oidx  <= '0;
            r_fin   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_oidx  <= n_oidx;
            r_fin   <= n_fin;
            r_final <= n_final;
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == 3'd7);

endmodule

### sv/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on shs_pkg, shs_ctrl and shs_datapath.
//
// Input channel (i_valid / o_stall): one transaction per message byte
// (i_mode = 0, i_data_byte) or one finish transaction (i_mode = 1).
// Output channel (o_valid / i_stall): eight transactions per finish, digest
// words 0..7 in big-endian byte order, o_last_word high on word 7.
// Sequence: an absorb transaction is accepted while idle; the 64th byte of a
// block starts a compression (load, 64 rounds at one round per cycle through
// a single round unit, chain add). A finish pads one byte per cycle up to the
// block end, runs one or two compressions, then presents the digest words.
// Two compressions run when fewer than nine bytes of the block were free.
// o_stall is high whenever the block is padding, compressing or emitting.
// When the receiver stalls, the current digest word holds until taken.
// Reset (synchronous, active low) restores the initial hash values and
// clears the byte and bit counters; after the eighth word the block
// returns to that state for the next message.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import shs_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    shs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd)
    );

    shs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_data_byte   (i_data_byte),
        .o_status      (dp_status),
        .o_digest_word (o_digest_word)
    );

endmodule
